[design/larq_pkg.sv]
// Shared types and constants of the line assembling ring queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package larq_pkg;

	localparam int ENTRY_BYTES_DEF = 64;
	localparam int SLOTS_DEF       = 16;

	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int LLEN_W   = 6;

	localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_END  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [STATUS_W-1:0] RSP_ACCEPT   = 3'd0;
	localparam logic [STATUS_W-1:0] RSP_REJECT   = 3'd1;
	localparam logic [STATUS_W-1:0] RSP_OVERFLOW = 3'd2;
	localparam logic [STATUS_W-1:0] RSP_NO_LINE  = 3'd3;
	localparam logic [STATUS_W-1:0] RSP_LINE     = 3'd4;

	localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic chunk_byte;
		logic chunk_end;
		logic no_line;
		logic read_start;
		logic stream_step;
	} larq_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic line_ready;
		logic out_free;
		logic last_idx;
	} larq_sts_t;

endpackage

[design/larq_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// Self-contained; holds no reset.
module larq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/larq_ctrl.sv]
// Controller of the line assembling ring queue: decodes input beats and sequences
// the read-out of a line. Depends on larq_pkg.
module larq_ctrl import larq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [CMD_W-1:0] cmd,
	input  larq_sts_t        sts,
	output logic             req_stall,
	output larq_ctl_t        ctl
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_STREAM = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	// Beats that produce a result need room in the response register.
	always_comb begin
		req_stall = 1'b1;
		if (state_q == S_IDLE) begin
			req_stall = !((cmd != CMD_END && cmd != CMD_READ) || sts.out_free);
		end
	end

	assign accept = req_valid && !req_stall;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_BYTE: begin
							ctl.chunk_byte = 1'b1;
						end
						CMD_END: begin
							ctl.chunk_end = 1'b1;
						end
						CMD_READ: begin
							if (sts.line_ready) begin
								ctl.read_start = 1'b1;
								state_d        = S_STREAM;
							end else begin
								ctl.no_line = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_STREAM: begin
				if (sts.out_free) begin
					ctl.stream_step = 1'b1;
					if (sts.last_idx) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/larq_dp.sv]
// Datapath of the line assembling ring queue: ring pointers, chunk tracking,
// slot byte and line length memories, and the response register.
// Depends on larq_pkg and larq_ram.
module larq_dp import larq_pkg::*; #(
	parameter int ENTRY_BYTES = ENTRY_BYTES_DEF,
	parameter int SLOTS       = SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  larq_ctl_t           ctl,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                rsp_stall,
	output larq_sts_t           sts,
	output logic                rsp_valid,
	output logic [STATUS_W-1:0] status,
	output logic [BYTE_W-1:0]   line_byte,
	output logic                last,
	output logic [LLEN_W-1:0]   line_length
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int LEN_W  = $clog2(ENTRY_BYTES);
	localparam int CNT_W  = $clog2(ENTRY_BYTES + 1);
	localparam int POS_W  = CNT_W + 1;
	localparam int ADDR_W = $clog2(SLOTS * ENTRY_BYTES);

	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic              full_q;
	logic [LEN_W-1:0]  head_len_q;
	logic [CNT_W-1:0]  count_q;
	logic              cnl_q;
	logic [LEN_W-1:0]  idx_q;
	logic              rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [BYTE_W-1:0] line_byte_q;
	logic              last_q;
	logic [LLEN_W-1:0] line_length_q;

	logic [SLOT_W-1:0] head_inc;
	logic [SLOT_W-1:0] tail_inc;
	logic [POS_W-1:0]  pos;
	logic              byte_store;
	logic [STATUS_W-1:0] end_status;
	logic              advance;
	logic              last_idx;
	logic [LEN_W-1:0]  idx_next;
	logic [LEN_W-1:0]  rd_idx;
	logic              out_free;
	logic [ADDR_W-1:0] store_waddr;
	logic [ADDR_W-1:0] store_raddr;
	logic [BYTE_W-1:0] store_rdata;
	logic [LEN_W-1:0]  len_rdata;

	assign head_inc = (head_q == SLOT_W'(SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == SLOT_W'(SLOTS - 1)) ? '0 : tail_q + 1'b1;

	// Bytes of the current chunk land right after the valid bytes of the head slot.
	assign pos = POS_W'(head_len_q) + POS_W'(count_q);

	// While the ring is full the head slot is the unread tail line, so nothing is stored.
	assign byte_store = ctl.chunk_byte && (data_byte != '0) && !full_q
		&& (pos < POS_W'(ENTRY_BYTES));

	always_comb begin
		if (count_q == '0 || count_q >= CNT_W'(ENTRY_BYTES) || full_q) begin
			end_status = RSP_REJECT;
		end else if (pos >= POS_W'(ENTRY_BYTES)) begin
			end_status = RSP_OVERFLOW;
		end else begin
			end_status = RSP_ACCEPT;
		end
	end

	assign advance = ctl.chunk_end && (end_status == RSP_ACCEPT) && cnl_q;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign last_idx = (idx_q == LEN_W'(len_rdata - 1'b1));
	assign idx_next = last_idx ? '0 : idx_q + 1'b1;
	assign rd_idx   = ctl.stream_step ? idx_next : idx_q;

	assign store_waddr = ADDR_W'(head_q) * ADDR_W'(ENTRY_BYTES) + ADDR_W'(pos[LEN_W-1:0]);
	assign store_raddr = ADDR_W'(tail_q) * ADDR_W'(ENTRY_BYTES) + ADDR_W'(rd_idx);

	larq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (SLOTS * ENTRY_BYTES)
	) u_store_ram (
		.clk   (clk),
		.we    (byte_store),
		.waddr (store_waddr),
		.wdata (data_byte),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	// Length of each completed line, written when the head leaves the slot.
	larq_ram #(
		.WIDTH (LEN_W),
		.DEPTH (SLOTS)
	) u_len_ram (
		.clk   (clk),
		.we    (advance),
		.waddr (head_q),
		.wdata (pos[LEN_W-1:0]),
		.raddr (tail_q),
		.rdata (len_rdata)
	);

	always_comb begin
		sts            = '0;
		sts.line_ready = (head_q != tail_q) || full_q;
		sts.out_free   = out_free;
		sts.last_idx   = last_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			full_q      <= 1'b0;
			head_len_q  <= '0;
			count_q     <= '0;
			cnl_q       <= 1'b0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.chunk_byte && data_byte != '0) begin
				if (count_q < CNT_W'(ENTRY_BYTES)) begin
					count_q <= count_q + 1'b1;
				end
				if (byte_store && data_byte == NEWLINE) begin
					cnl_q <= 1'b1;
				end
			end
			if (ctl.chunk_end) begin
				count_q <= '0;
				cnl_q   <= 1'b0;
				if (end_status == RSP_OVERFLOW) begin
					head_len_q <= '0;
				end else if (end_status == RSP_ACCEPT) begin
					if (cnl_q) begin
						head_len_q <= '0;
						head_q     <= head_inc;
						if (head_inc == tail_q) begin
							full_q <= 1'b1;
						end
					end else begin
						head_len_q <= pos[LEN_W-1:0];
					end
				end
			end
			// A line read always starts from the first byte of the tail slot.
			if (ctl.read_start) begin
				idx_q <= '0;
			end else if (ctl.stream_step) begin
				idx_q <= idx_next;
				if (last_idx) begin
					tail_q <= tail_inc;
					full_q <= 1'b0;
					// Reading the head slot spoils any chunk that is still being built.
					if (head_q == tail_q) begin
						head_len_q <= '0;
						if (count_q != '0) begin
							count_q <= CNT_W'(ENTRY_BYTES);
						end
					end
				end
			end
			if (ctl.chunk_end || ctl.no_line || ctl.stream_step) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.chunk_end || ctl.no_line) begin
			status_q      <= ctl.chunk_end ? end_status : RSP_NO_LINE;
			line_byte_q   <= '0;
			last_q        <= 1'b1;
			line_length_q <= '0;
		end else if (ctl.stream_step) begin
			status_q      <= RSP_LINE;
			line_byte_q   <= store_rdata;
			last_q        <= last_idx;
			line_length_q <= LLEN_W'(len_rdata);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign line_byte   = line_byte_q;
	assign last        = last_q;
	assign line_length = line_length_q;

`ifndef ASSERT_OFF
	a_full_pointers: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (head_q == tail_q))
		else $error("ring full while head and tail differ");

	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.stream_step |-> out_free)
		else $error("line byte loaded into an occupied response register");

	a_line_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.stream_step |-> (len_rdata != '0))
		else $error("streaming a line of zero length");

	a_no_store_full: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) && full_q |-> (head_len_q == '0) && (count_q == '0))
		else $error("chunk state not cleared when the ring filled");
`endif

endmodule

[design/line_assembling_ring_queue.sv]
// Line assembling ring queue: builds text lines from chunks in a ring of slots.
// Top level; depends on larq_pkg, larq_ctrl, larq_dp and larq_ram.
//
// Request channel (req_valid, req_stall, cmd, data_byte): a chunk byte beat
// (CMD_BYTE) is taken every cycle outside a line read and gives no response;
// a zero byte is ignored.
// An end of chunk beat (CMD_END) gives one response beat with the outcome.
// A read beat (CMD_READ) gives one "no line" beat, or the tail line one byte per
// beat, with last set on the final byte and line_length on every byte.
// Response channel (rsp_valid, rsp_stall, status, line_byte, last, line_length)
// is a single output register; a stalled response holds its value.
// The response to an end of chunk or an empty read is registered and appears in the
// cycle after the request beat. A line read streams the tail line from the registered
// read of the slot byte memory into the response register, one byte per cycle while
// the receiver does not stall; the request channel is stalled until the last byte of
// the line has been loaded.
// End of chunk and read beats are stalled while the response register is full
// and the receiver stalls; chunk bytes still flow.
// Reset empties the ring at once; there is no clearing pass after reset.
module line_assembling_ring_queue import larq_pkg::*; #(
	parameter int ENTRY_BYTES = ENTRY_BYTES_DEF,
	parameter int SLOTS       = SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [BYTE_W-1:0]   data_byte,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic [BYTE_W-1:0]   line_byte,
	output logic                last,
	output logic [LLEN_W-1:0]   line_length
);

	larq_ctl_t ctl;
	larq_sts_t sts;

	larq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.cmd       (cmd),
		.sts       (sts),
		.req_stall (req_stall),
		.ctl       (ctl)
	);

	larq_dp #(
		.ENTRY_BYTES (ENTRY_BYTES),
		.SLOTS       (SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.data_byte   (data_byte),
		.rsp_stall   (rsp_stall),
		.sts         (sts),
		.rsp_valid   (rsp_valid),
		.status      (status),
		.line_byte   (line_byte),
		.last        (last),
		.line_length (line_length)
	);

endmodule

[tb/sv/larq_response_check.sv]
// Response checker for the line assembling ring queue: tracks the ring on request beats
// and compares every response beat with the expected one. Depends on larq_pkg.
module larq_response_check import larq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [BYTE_W-1:0]   line_byte,
	input  logic                last,
	input  logic [LLEN_W-1:0]   line_length,
	output int                  mismatches,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_BYTES = ENTRY_BYTES_DEF;
	localparam int RING_SLOTS = SLOTS_DEF;
	localparam int COUNT_CAP  = 127;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   line_byte;
		logic                last;
		logic [LLEN_W-1:0]   line_length;
	} rsp_beat_t;

	rsp_beat_t due_beats[$];

	bit [BYTE_W-1:0] slot_bytes [RING_SLOTS*LINE_BYTES];
	int unsigned     fill_len [RING_SLOTS];
	bit              line_done [RING_SLOTS];
	int unsigned     wr_slot;
	int unsigned     rd_slot;
	bit              ring_is_full;
	int unsigned     pend_count;
	bit              pend_newline;

	function automatic void queue_beat(input logic [STATUS_W-1:0] st,
			input logic [BYTE_W-1:0] b, input logic l, input logic [LLEN_W-1:0] len);
		rsp_beat_t beat;
		beat.status      = st;
		beat.line_byte   = b;
		beat.last        = l;
		beat.line_length = len;
		due_beats.push_back(beat);
	endfunction

	function void clear_ring();
		foreach (slot_bytes[i]) slot_bytes[i] = '0;
		foreach (fill_len[i]) begin
			fill_len[i]  = 0;
			line_done[i] = 1'b0;
		end
		wr_slot      = 0;
		rd_slot      = 0;
		ring_is_full = 1'b0;
		pend_count   = 0;
		pend_newline = 1'b0;
	endfunction

	// Chunk bytes go straight into the head slot behind its valid bytes; only the end
	// of the chunk decides whether they count.
	function void note_chunk_byte(input logic [BYTE_W-1:0] b);
		int unsigned pos;
		pos = fill_len[wr_slot] + pend_count;
		if (b == 8'h00)
			return;
		if (pos < LINE_BYTES) begin
			slot_bytes[wr_slot*LINE_BYTES + pos] = b;
			if (b == NEWLINE)
				pend_newline = 1'b1;
		end
		if (pend_count < COUNT_CAP)
			pend_count++;
	endfunction

	function void close_chunk();
		int unsigned len;
		bit          nl;
		len          = pend_count;
		nl           = pend_newline;
		pend_count   = 0;
		pend_newline = 1'b0;
		if (len == 0 || len >= LINE_BYTES || ring_is_full) begin
			queue_beat(RSP_REJECT, '0, 1'b1, '0);
		end else if (fill_len[wr_slot] + len >= LINE_BYTES) begin
			fill_len[wr_slot]  = 0;
			line_done[wr_slot] = 1'b0;
			queue_beat(RSP_OVERFLOW, '0, 1'b1, '0);
		end else begin
			fill_len[wr_slot] += len;
			if (nl)
				line_done[wr_slot] = 1'b1;
			if (line_done[wr_slot]) begin
				wr_slot = (wr_slot + 1) % RING_SLOTS;
				if (wr_slot == rd_slot)
					ring_is_full = 1'b1;
			end
			queue_beat(RSP_ACCEPT, '0, 1'b1, '0);
		end
	endfunction

	function void read_tail_line();
		int unsigned len;
		len = fill_len[rd_slot];
		if (!line_done[rd_slot] || len == 0 || (wr_slot == rd_slot && !ring_is_full)) begin
			queue_beat(RSP_NO_LINE, '0, 1'b1, '0);
			return;
		end
		if (len > LINE_BYTES - 1)
			len = LINE_BYTES - 1;
		for (int unsigned i = 0; i < len; i++)
			queue_beat(RSP_LINE, slot_bytes[rd_slot*LINE_BYTES + i], i + 1 == len,
				LLEN_W'(len));
		fill_len[rd_slot]  = 0;
		line_done[rd_slot] = 1'b0;
		// Emptying the slot under a chunk in progress dooms that chunk.
		if (wr_slot == rd_slot && pend_count > 0)
			pend_count = COUNT_CAP;
		rd_slot      = (rd_slot + 1) % RING_SLOTS;
		ring_is_full = 1'b0;
	endfunction

	always @(posedge clk) begin
		rsp_beat_t want;
		if (!arst_n) begin
			clear_ring();
			due_beats.delete();
		end else begin
			// Responses are checked before this edge's request is modeled.
			if (rsp_valid && !rsp_stall) begin
				if (due_beats.size() == 0) begin
					$display("%0t: unexpected response beat, status %0d byte %h",
						$time, status, line_byte);
					mismatches++;
				end else begin
					want = due_beats.pop_front();
					if (want.status !== status || want.line_byte !== line_byte ||
							want.last !== last || want.line_length !== line_length) begin
						$display({"%0t: expected st %0d byte %h last %0b len %0d, ",
							"got st %0d byte %h last %0b len %0d"}, $time,
							want.status, want.line_byte, want.last, want.line_length,
							status, line_byte, last, line_length);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				case (cmd)
					CMD_BYTE: note_chunk_byte(data_byte);
					CMD_END:  close_chunk();
					CMD_READ: read_tail_line();
					default: ;
				endcase
			end
		end
		pending = due_beats.size();
	end

endmodule

[tb/sv/line_assembling_ring_queue_test.sv]
// Testbench top for the line assembling ring queue: drives request beats in bursts,
// stalls responses, gives the verdict. Uses larq_pkg, larq_response_check, the DUT.
module line_assembling_ring_queue_test import larq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ITEM_TARGET = 320;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;
	typedef enum int {EP_FILL, EP_LONG, EP_OVERFLOW, EP_MIXED} episode_t;
	typedef enum int {NL_NONE, NL_RANDOM, NL_AT_END} nl_plan_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic [CMD_W-1:0]    cmd       = CMD_BYTE;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic                rsp_stall = 1'b0;
	logic                req_stall;
	logic                rsp_valid;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   line_byte;
	logic                last;
	logic [LLEN_W-1:0]   line_length;

	int          mismatches;
	int          pending;
	int          items_sent  = 0;
	int          burst_left  = 0;
	int          cycle_count = 0;
	stall_mode_t stall_mode  = STALL_NONE;
	int          stall_left  = 0;

	line_assembling_ring_queue i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.line_byte   (line_byte),
		.last        (last),
		.line_length (line_length)
	);

	larq_response_check i_rsp_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.line_byte   (line_byte),
		.last        (last),
		.line_length (line_length),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	always #1ns clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The receiver switches between stall patterns chosen at random.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 160);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
			default:     rsp_stall <= (stall_left % 9) < 4;
		endcase
	end

	// One request beat; a new burst starts with a random gap.
	task automatic put_beat(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		cmd       <= c;
		data_byte <= b;
		do @(posedge clk); while (req_stall);
		if (c != CMD_UNUSED && !(c == CMD_BYTE && b == 8'h00))
			items_sent++;
	endtask

	task automatic send_chunk(input int n, input nl_plan_t plan);
		logic [BYTE_W-1:0] b;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 24) == 0)
				put_beat(CMD_BYTE, 8'h00);
			b = BYTE_W'($urandom_range(1, 255));
			if (plan == NL_AT_END && i == n - 1)
				b = NEWLINE;
			else if (plan == NL_RANDOM && $urandom_range(0, 9) == 0)
				b = NEWLINE;
			else if (plan != NL_RANDOM && b == NEWLINE)
				b = 8'h0B;
			put_beat(CMD_BYTE, b);
		end
		put_beat(CMD_END, BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	initial begin
		int       episode;
		episode_t kind;
		int       pick;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_beat(CMD_READ, 8'h00);
		put_beat(CMD_END, 8'hFF);
		put_beat(CMD_UNUSED, 8'h5A);
		put_beat(CMD_BYTE, 8'h00);
		put_beat(CMD_BYTE, 8'hFF);
		put_beat(CMD_BYTE, 8'h01);
		put_beat(CMD_BYTE, NEWLINE);
		put_beat(CMD_BYTE, 8'h80);
		put_beat(CMD_END, 8'h00);
		put_beat(CMD_READ, 8'hFF);
		put_beat(CMD_READ, 8'h00);
		// A partial line in the only slot in use is not a line yet.
		put_beat(CMD_BYTE, 8'h78);
		put_beat(CMD_END, 8'h00);
		put_beat(CMD_READ, 8'h00);
		drain_responses();

		episode = 0;
		while (items_sent < ITEM_TARGET) begin
			if (episode < 3) begin
				kind = episode_t'(episode);
			end else begin
				pick = $urandom_range(0, 9);
				kind = (pick < 3) ? episode_t'(pick) : EP_MIXED;
			end
			case (kind)
				EP_FILL: begin
					repeat ($urandom_range(17, 18))
						send_chunk($urandom_range(1, 3), NL_AT_END);
					// Start a chunk on the full ring and read away the slot beneath it.
					repeat ($urandom_range(1, 3))
						put_beat(CMD_BYTE, BYTE_W'($urandom_range(1, 255)));
					put_beat(CMD_READ, 8'h00);
					put_beat(CMD_END, 8'h00);
					repeat (SLOTS_DEF + 1)
						put_beat(CMD_READ, BYTE_W'($urandom_range(0, 255)));
				end
				EP_LONG: begin
					send_chunk((episode == 1) ? 63 : $urandom_range(60, 66), NL_AT_END);
					put_beat(CMD_READ, 8'h00);
					put_beat(CMD_READ, 8'h00);
				end
				EP_OVERFLOW: begin
					repeat ($urandom_range(3, 5))
						send_chunk($urandom_range(12, 30), NL_NONE);
					put_beat(CMD_READ, 8'h00);
				end
				default: begin
					repeat ($urandom_range(3, 8)) begin
						pick = $urandom_range(0, 99);
						if (pick < 55) begin
							send_chunk(($urandom_range(0, 3) == 0) ?
								$urandom_range(7, 24) : $urandom_range(1, 6), NL_RANDOM);
						end else if (pick < 65) begin
							put_beat(CMD_END, BYTE_W'($urandom_range(0, 255)));
						end else if (pick < 90) begin
							put_beat(CMD_READ, BYTE_W'($urandom_range(0, 255)));
						end else if (pick < 95) begin
							put_beat(CMD_UNUSED, BYTE_W'($urandom_range(0, 255)));
						end else begin
							repeat ($urandom_range(1, 4))
								put_beat(CMD_BYTE, BYTE_W'($urandom_range(0, 255)));
							put_beat(CMD_READ, 8'h00);
							put_beat(CMD_END, 8'h00);
						end
					end
				end
			endcase
			if (episode == 0 || $urandom_range(0, 3) == 0)
				drain_responses();
			episode++;
		end

		req_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (ENTRY_BYTES_DEF + 8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
